// File: rtl/core/clrl_pkg.sv
`timescale 1ns / 1ps
// shared sizes, request codes and controller/datapath handshake types
package clrl_pkg;

    // pool and field sizes
    localparam int NODE_COUNT = 16;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam int REQ_W      = 2;

    // request codes, the fourth code is unused and rejected
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD     = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_ADVANCE = 2'd2
    } req_t;

    // per-cycle commands from controller to datapath
    typedef struct packed {
        logic capture;        // latch the incoming word
        logic add_first;      // add into an empty ring
        logic add_start;      // store data in free slot, read link of current
        logic add_splice;     // link new slot to old successor
        logic add_close;      // link current to new slot
        logic rd_cur_link;    // read link of current
        logic rm_only;        // drop the only node
        logic rm_begin_walk;  // save successor, start predecessor walk
        logic walk_step;      // follow one link
        logic rm_unlink;      // bypass current, successor becomes current
        logic adv_move;       // current moves to successor
        logic load_data;      // refresh cached current data
        logic set_ok;         // request took effect
        logic out_load;       // load the result registers
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req_code;
        logic             full;
        logic             empty;
        logic             link_is_cur;
    } status_t;

endpackage

// File: rtl/core/clrl_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module clrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/clrl_ctrl.sv
`timescale 1ns / 1ps
// request sequencer: steps each request through the datapath
module clrl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  clrl_pkg::status_t stat,
    output clrl_pkg::cmd_t    cmd
);
    import clrl_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DISPATCH = 7'b0000010,
        ST_LREAD    = 7'b0000100,
        ST_SPLICE   = 7'b0001000,
        ST_WALK     = 7'b0010000,
        ST_DREAD    = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_DONE;
                unique case (stat.req_code)
                    REQ_ADD:
                    begin
                        if (!stat.full)
                        begin
                            cmd.set_ok = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.add_first = 1'b1;
                            end
                            else
                            begin
                                cmd.add_start = 1'b1;
                                state_next    = ST_LREAD;
                            end
                        end
                    end
                    REQ_REMOVE, REQ_ADVANCE:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.set_ok      = 1'b1;
                            cmd.rd_cur_link = 1'b1;
                            state_next      = ST_LREAD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_LREAD:
            begin
                unique case (stat.req_code)
                    REQ_ADD:
                    begin
                        cmd.add_splice = 1'b1;
                        state_next     = ST_SPLICE;
                    end
                    REQ_REMOVE:
                    begin
                        if (stat.link_is_cur)
                        begin
                            cmd.rm_only = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            cmd.rm_begin_walk = 1'b1;
                            state_next        = ST_WALK;
                        end
                    end
                    default:
                    begin
                        cmd.adv_move = 1'b1;
                        state_next   = ST_DREAD;
                    end
                endcase
            end
            ST_SPLICE:
            begin
                cmd.add_close = 1'b1;
                state_next    = ST_DONE;
            end
            ST_WALK:
            begin
                if (stat.link_is_cur)
                begin
                    cmd.rm_unlink = 1'b1;
                    state_next    = ST_DREAD;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_DREAD:
            begin
                cmd.load_data = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result word handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/clrl_dp.sv
`timescale 1ns / 1ps
// ring datapath: slot flags, link and data memories, pointers and result registers
module clrl_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  clrl_pkg::cmd_t                cmd,
    output clrl_pkg::status_t             stat,
    input  logic [clrl_pkg::REQ_W-1:0]    req_type,
    input  logic [clrl_pkg::DATA_W-1:0]   item_data,
    output logic                          accepted,
    output logic                          current_valid,
    output logic [clrl_pkg::DATA_W-1:0]   current_data,
    output logic                          is_empty,
    output logic [clrl_pkg::CNT_W-1:0]    node_count
);
    import clrl_pkg::*;

    // request word
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [DATA_W-1:0]     item_reg, item_next;
    logic                  ok_reg, ok_next;

    // ring state
    logic [NODE_COUNT-1:0] used_reg, used_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic                  nonempty_reg, nonempty_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_W-1:0]     cur_data_reg, cur_data_next;

    // scratch pointers
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [IDX_W-1:0]      after_reg, after_next;
    logic [IDX_W-1:0]      prev_reg, prev_next;

    // result word
    logic                  res_ok_reg, res_ok_next;
    logic                  res_valid_reg, res_valid_next;
    logic [DATA_W-1:0]     res_data_reg, res_data_next;
    logic                  res_empty_reg, res_empty_next;
    logic [CNT_W-1:0]      res_count_reg, res_count_next;

    // memory ports
    logic                  link_wr_en, link_rd_en;
    logic [IDX_W-1:0]      link_wr_addr, link_wr_data, link_rd_addr, link_rd;
    logic                  data_wr_en, data_rd_en;
    logic [IDX_W-1:0]      data_wr_addr, data_rd_addr;
    logic [DATA_W-1:0]     data_rd;

    // lowest free slot
    logic [IDX_W-1:0]      free_slot;
    logic                  free_found;

    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            if (!used_reg[i] && !free_found)
            begin
                free_slot  = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    // status to controller
    assign stat.req_code    = req_reg;
    assign stat.full        = (count_reg == CNT_W'(NODE_COUNT));
    assign stat.empty       = !nonempty_reg;
    assign stat.link_is_cur = (link_rd == cur_reg);

    // link memory port selection
    always_comb
    begin
        link_wr_en   = cmd.add_first | cmd.add_splice | cmd.add_close | cmd.rm_unlink;
        link_wr_addr = free_slot;
        link_wr_data = free_slot;
        if (cmd.add_splice)
        begin
            link_wr_addr = slot_reg;
            link_wr_data = link_rd;
        end
        else if (cmd.add_close)
        begin
            link_wr_addr = cur_reg;
            link_wr_data = slot_reg;
        end
        else if (cmd.rm_unlink)
        begin
            link_wr_addr = prev_reg;
            link_wr_data = after_reg;
        end
        link_rd_en   = cmd.add_start | cmd.rd_cur_link | cmd.rm_begin_walk | cmd.walk_step;
        link_rd_addr = (cmd.rm_begin_walk | cmd.walk_step) ? link_rd : cur_reg;
    end

    // data memory port selection
    assign data_wr_en   = cmd.add_first | cmd.add_start;
    assign data_wr_addr = free_slot;
    assign data_rd_en   = cmd.rm_unlink | cmd.adv_move;
    assign data_rd_addr = cmd.rm_unlink ? after_reg : link_rd;

    clrl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NODE_COUNT)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd)
    );

    clrl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODE_COUNT)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (data_wr_addr),
        .wr_data (item_reg),
        .rd_en   (data_rd_en),
        .rd_addr (data_rd_addr),
        .rd_data (data_rd)
    );

    // request capture and ring state update
    always_comb
    begin
        req_next      = req_reg;
        item_next     = item_reg;
        ok_next       = ok_reg;
        used_next     = used_reg;
        cur_next      = cur_reg;
        nonempty_next = nonempty_reg;
        count_next    = count_reg;
        cur_data_next = cur_data_reg;
        slot_next     = slot_reg;
        after_next    = after_reg;
        prev_next     = prev_reg;

        if (cmd.capture)
        begin
            req_next  = req_type;
            item_next = item_data;
            ok_next   = 1'b0;
        end
        if (cmd.set_ok)
        begin
            ok_next = 1'b1;
        end
        // empty ring: new node links to itself
        if (cmd.add_first)
        begin
            used_next[free_slot] = 1'b1;
            cur_next             = free_slot;
            cur_data_next        = item_reg;
            nonempty_next        = 1'b1;
            count_next           = count_reg + 1'b1;
        end
        if (cmd.add_start)
        begin
            slot_next = free_slot;
        end
        if (cmd.add_close)
        begin
            used_next[slot_reg] = 1'b1;
            count_next          = count_reg + 1'b1;
        end
        // last node leaves, current index stays put
        if (cmd.rm_only)
        begin
            used_next[cur_reg] = 1'b0;
            nonempty_next      = 1'b0;
            count_next         = count_reg - 1'b1;
        end
        if (cmd.rm_begin_walk)
        begin
            after_next = link_rd;
            prev_next  = link_rd;
        end
        if (cmd.walk_step)
        begin
            prev_next = link_rd;
        end
        if (cmd.rm_unlink)
        begin
            used_next[cur_reg] = 1'b0;
            cur_next           = after_reg;
            count_next         = count_reg - 1'b1;
        end
        if (cmd.adv_move)
        begin
            cur_next = link_rd;
        end
        if (cmd.load_data)
        begin
            cur_data_next = data_rd;
        end
    end

    // result word
    always_comb
    begin
        res_ok_next    = res_ok_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        res_empty_next = res_empty_reg;
        res_count_next = res_count_reg;
        if (cmd.out_load)
        begin
            res_ok_next    = ok_reg;
            res_valid_next = nonempty_reg;
            res_data_next  = nonempty_reg ? cur_data_reg : '0;
            res_empty_next = (count_reg == '0);
            res_count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            cur_reg      <= '0;
            nonempty_reg <= 1'b0;
            count_reg    <= '0;
            ok_reg       <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            cur_reg      <= cur_next;
            nonempty_reg <= nonempty_next;
            count_reg    <= count_next;
            ok_reg       <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        item_reg      <= item_next;
        cur_data_reg  <= cur_data_next;
        slot_reg      <= slot_next;
        after_reg     <= after_next;
        prev_reg      <= prev_next;
        res_ok_reg    <= res_ok_next;
        res_valid_reg <= res_valid_next;
        res_data_reg  <= res_data_next;
        res_empty_reg <= res_empty_next;
        res_count_reg <= res_count_next;
    end

    assign accepted      = res_ok_reg;
    assign current_valid = res_valid_reg;
    assign current_data  = res_data_reg;
    assign is_empty      = res_empty_reg;
    assign node_count    = res_count_reg;

endmodule

// File: rtl/core/circular_ring_list_engine.sv
`timescale 1ns / 1ps
// top level of the circular ring list engine
// A pool of 16 nodes kept as one circular ring with a current pointer, for
// round-robin scheduling. Each input word is an add (lowest free slot, linked
// right after current; becomes current on an empty ring), a remove (current is
// unlinked, its successor becomes current) or an advance; each gives exactly
// one result word with the ring status after the request. One request is in
// flight at a time. A remove of any node but the last walks from the
// successor to the predecessor through the link memory, one link per cycle,
// following up to count - 2 links. While an earlier result word is held back
// by out_ready, a finished request waits in ST_DONE. No clearing pass is
// needed after reset.
module circular_ring_list_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [clrl_pkg::REQ_W-1:0]    req_type,
    input  logic [clrl_pkg::DATA_W-1:0]   item_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          accepted,
    output logic                          current_valid,
    output logic [clrl_pkg::DATA_W-1:0]   current_data,
    output logic                          is_empty,
    output logic [clrl_pkg::CNT_W-1:0]    node_count
);
    import clrl_pkg::*;

    cmd_t    cmd;
    status_t stat;

    // sequencer
    clrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // ring storage and pointers
    clrl_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .item_data     (item_data),
        .accepted      (accepted),
        .current_valid (current_valid),
        .current_data  (current_data),
        .is_empty      (is_empty),
        .node_count    (node_count)
    );

endmodule

// File: rtl/core/clrl_checker.sv
`timescale 1ns / 1ps
// port-level checks for the ring engine, bound to the top level
module clrl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          accepted,
    input logic                          current_valid,
    input logic [clrl_pkg::DATA_W-1:0]   current_data,
    input logic                          is_empty,
    input logic [clrl_pkg::CNT_W-1:0]    node_count
);
    import clrl_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(accepted)
            && $stable(current_data) && $stable(node_count))
        else $error("result word changed while stalled");

    // empty flag matches count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (node_count == '0)))
        else $error("is_empty disagrees with node_count");

    // current pointer valid exactly when ring has nodes
    a_valid_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (current_valid == !is_empty))
        else $error("current_valid disagrees with is_empty");

    // empty ring reports zero data
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !current_valid |-> (current_data == '0))
        else $error("data reported on empty ring");

    // count never exceeds the pool
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (node_count <= CNT_W'(NODE_COUNT)))
        else $error("node_count above pool size");

endmodule

bind circular_ring_list_engine clrl_checker u_clrl_checker (.*);
